### rtl/sbh_pkg.sv
// ----------------------------------------------------------------------------
// sbh_pkg
// Shared types and constants for the string key dual hash block.
// ----------------------------------------------------------------------------
package sbh_pkg;

  // Default number of bytes kept for a short key (range 1 to 8)
  localparam int unsigned ShortLimitDef = 8;

  // Width of the per-string byte counter (saturates at ShortLimit + 1)
  localparam int unsigned CountW = 4;

  // One input beat: a string byte and its end marker
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_beat_t;

  // One result beat
  typedef struct packed {
    logic [63:0] key;
    logic        was_short;
  } out_beat_t;

endpackage

### rtl/string_key_dual_hash.sv
// ----------------------------------------------------------------------------
// string_key_dual_hash
// Turns a byte string into one 64-bit key: short strings packed, longer
// strings as BKDR (high word) and djb2 (low word) sums.
// ----------------------------------------------------------------------------
// Use:
//   Input channel: one string byte per beat (data_byte) plus is_last on the
//   final byte. Every string has at least one byte.
//   Output channel: one beat per string, on its last byte: key and was_short.
//   Strings of up to ShortLimit bytes give the raw bytes little-endian,
//   zero-padded; longer ones give {bkdr, djb2}.
//   cfg_we_i/cfg_wdata_i write signed_bytes (reset 1): 1 adds bytes to the
//   sums as signed char, 0 as unsigned. Write only while the block is idle.
// Timing:
//   Throughput is one byte per cycle while no last byte waits on a stalled
//   output. A byte is taken into the input register; from there the sum update
//   and key selection run in one pass and the key lands in the result register.
//   The per-byte recurrence (x*131 + b, x*33 + b as shift-adds) is combinational
//   between the state registers.
// Reset:
//   Clears both pipeline stages, the string state (djb2 back to 5381) and
//   sets signed_bytes. No clearing pass; bytes are accepted straight away.
// Stall:
//   While the output stalls, bytes that are not last still flow through.
//   A last byte waits in the input register until the result register is
//   free, and in_stall_o is then raised.
// ----------------------------------------------------------------------------
module string_key_dual_hash
  import sbh_pkg::*;
#(
  parameter int unsigned ShortLimit = ShortLimitDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  // configuration
  logic signed_q, signed_d;

  // input register
  logic     s1_valid_q, s1_valid_d;
  in_beat_t s1_q, s1_d;

  logic      out_free;
  logic      proc;
  logic      in_take;
  out_beat_t res;

  assign signed_d = cfg_we_i ? cfg_wdata_i : signed_q;

  // a byte is worked on unless it is last and the result slot is still full
  assign proc       = s1_valid_q && (!s1_q.is_last || out_free);
  assign in_stall_o = s1_valid_q && !proc;
  assign in_take    = in_valid_i && !in_stall_o;

  assign s1_valid_d = in_take || (s1_valid_q && !proc);
  assign s1_d       = in_take ? in_data_i : s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_q   <= 1'b1;
      s1_valid_q <= 1'b0;
    end else begin
      signed_q   <= signed_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  // sums, leading bytes and key forming
  sbh_hash_core #(
    .ShortLimit(ShortLimit)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .proc_i  (proc),
    .beat_i  (s1_q),
    .signed_i(signed_q),
    .res_o   (res)
  );

  // result register
  sbh_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (proc && s1_q.is_last),
    .beat_i     (res),
    .free_o     (out_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  a_stall_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_q.is_last))
    else $error("input stalled without a waiting last byte");

  a_result_from_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(proc && s1_q.is_last))
    else $error("result without a last byte");

  a_held_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !proc) |=> (s1_valid_q && $stable(s1_q)))
    else $error("waiting byte lost or changed");

endmodule

### rtl/sbh_hash_core.sv
// ----------------------------------------------------------------------------
// sbh_hash_core
// Per-string state (BKDR sum, djb2 sum, leading bytes, byte count) and the
// combinational update for one byte, with the key formed on the last byte.
// ----------------------------------------------------------------------------
module sbh_hash_core
  import sbh_pkg::*;
#(
  parameter int unsigned ShortLimit = ShortLimitDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      proc_i,
  input  in_beat_t  beat_i,
  input  logic      signed_i,
  output out_beat_t res_o
);

  localparam logic [31:0]       Djb2Init = 32'd5381;
  localparam logic [CountW-1:0] CountSat = CountW'(ShortLimit + 1);

  logic [31:0]       bkdr_q, bkdr_d, bkdr_upd;
  logic [31:0]       djb2_q, djb2_d, djb2_upd;
  logic [63:0]       short_q, short_d, short_upd;
  logic [CountW-1:0] count_q, count_d, count_upd;
  logic [31:0]       addend;
  logic              is_short;

  // sign-extend as a C char when asked to
  assign addend = {{24{signed_i & beat_i.data_byte[7]}}, beat_i.data_byte};

  // x*131 = x<<7 + x<<1 + x ; x*33 = x<<5 + x (wrapping mod 2^32)
  assign bkdr_upd = (bkdr_q << 7) + (bkdr_q << 1) + bkdr_q + addend;
  assign djb2_upd = (djb2_q << 5) + djb2_q + addend;

  always_comb begin
    short_upd = short_q;
    for (int i = 0; i < 8; i++) begin
      if (i < ShortLimit && count_q == CountW'(i)) begin
        short_upd[8*i +: 8] = beat_i.data_byte;
      end
    end
  end

  assign count_upd = (count_q < CountSat) ? count_q + CountW'(1) : count_q;
  assign is_short  = (count_upd <= CountW'(ShortLimit));

  always_comb begin
    res_o.was_short = is_short;
    res_o.key       = is_short ? short_upd : {bkdr_upd, djb2_upd};
  end

  always_comb begin
    bkdr_d  = bkdr_q;
    djb2_d  = djb2_q;
    short_d = short_q;
    count_d = count_q;
    if (proc_i) begin
      if (beat_i.is_last) begin
        bkdr_d  = '0;
        djb2_d  = Djb2Init;
        short_d = '0;
        count_d = '0;
      end else begin
        bkdr_d  = bkdr_upd;
        djb2_d  = djb2_upd;
        short_d = short_upd;
        count_d = count_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bkdr_q  <= '0;
      djb2_q  <= Djb2Init;
      short_q <= '0;
      count_q <= '0;
    end else begin
      bkdr_q  <= bkdr_d;
      djb2_q  <= djb2_d;
      short_q <= short_d;
      count_q <= count_d;
    end
  end

  a_count_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountSat)
    else $error("byte count beyond saturation");

  a_clear_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_i && beat_i.is_last) |=>
      (count_q == '0 && djb2_q == Djb2Init && bkdr_q == '0 && short_q == '0))
    else $error("string state not cleared after last byte");

  a_short_len_bits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (short_q == '0))
    else $error("short bytes held with empty count");

endmodule

### rtl/sbh_out_reg.sv
// ----------------------------------------------------------------------------
// sbh_out_reg
// Result register: holds one key beat until the receiver takes it.
// ----------------------------------------------------------------------------
module sbh_out_reg
  import sbh_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_beat_t beat_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  logic      valid_q, valid_d;
  out_beat_t data_q, data_d;

  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i || (valid_q && out_stall_i);
  assign data_d  = load_i ? beat_i : data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result loaded over an unsent beat");

  a_load_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (valid_q && data_q == $past(beat_i)))
    else $error("loaded result not presented");

  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_stall_i && !load_i) |=> !valid_q)
    else $error("result repeated after being taken");

endmodule

### dv/string_key_dual_hash_checker.sv
// ----------------------------------------------------------------------------
// string_key_dual_hash_checker
// Watches the input, result and register ports of the key block. It keeps
// its own running BKDR and djb2 sums and short-string bytes, queues the key
// due for every last byte and compares each result beat with the oldest key.
// ----------------------------------------------------------------------------
module string_key_dual_hash_checker
  import sbh_pkg::*;
#(
  parameter int unsigned ShortLimit = ShortLimitDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_beat_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_beat_t out_data_i,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  output int        pending_o,
  output int        fails_o,
  output int        keys_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MaxReports = 10;
  localparam logic [31:0] BkdrMul    = 32'd131;
  localparam logic [31:0] Djb2Mul    = 32'd33;
  localparam logic [31:0] Djb2Seed   = 32'd5381;

  logic              sign_ext_q;
  logic [31:0]       bkdr_q;
  logic [31:0]       djb2_q;
  logic [63:0]       head_q;
  logic [CountW-1:0] len_q;
  out_beat_t         due_keys[$];
  int                fails;
  int                keys_seen;

  task automatic restart_string();
    bkdr_q = '0;
    djb2_q = Djb2Seed;
    head_q = '0;
    len_q  = '0;
  endtask

  // One accepted byte: update both sums, keep the head bytes, queue a key on the last byte.
  task automatic absorb_byte(input in_beat_t beat);
    logic [31:0] addend;
    out_beat_t   key_due;
    addend = {24'h0, beat.data_byte};
    if (sign_ext_q && beat.data_byte[7]) begin
      addend[31:8] = '1;
    end
    bkdr_q = bkdr_q * BkdrMul + addend;
    djb2_q = djb2_q * Djb2Mul + addend;
    if (len_q < ShortLimit && len_q < 8) begin
      head_q = head_q | (64'(beat.data_byte) << (8 * len_q));
    end
    if (len_q < ShortLimit + 1) begin
      len_q = len_q + 1'b1;
    end
    if (beat.is_last) begin
      key_due.was_short = (len_q <= ShortLimit);
      key_due.key       = key_due.was_short ? head_q : {bkdr_q, djb2_q};
      due_keys.push_back(key_due);
      restart_string();
    end
  endtask

  task automatic compare_key(input out_beat_t got);
    out_beat_t want;
    if (due_keys.size() == 0) begin
      fails++;
      if (fails <= MaxReports) begin
        $display("%t: key beat with none due: key %h short %b",
                 $realtime, got.key, got.was_short);
      end
    end else begin
      want = due_keys.pop_front();
      keys_seen++;
      if (got.key !== want.key || got.was_short !== want.was_short) begin
        fails++;
        if (fails <= MaxReports) begin
          $display("%t: key mismatch: key exp %h got %h, short exp %b got %b",
                   $realtime, want.key, got.key, want.was_short, got.was_short);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sign_ext_q = 1'b1;
      restart_string();
      due_keys.delete();
      fails     = 0;
      keys_seen = 0;
    end else begin
      // results leave only after their last byte has been accepted, so pop before push
      if (out_valid_i && !out_stall_i) begin
        compare_key(out_data_i);
      end
      if (in_valid_i && !in_stall_i) begin
        absorb_byte(in_data_i);
      end
      if (cfg_we_i) begin
        sign_ext_q = cfg_wdata_i;
      end
    end
    pending_o   <= due_keys.size();
    fails_o     <= fails;
    keys_seen_o <= keys_seen;
  end

endmodule

### dv/string_key_dual_hash_tb.sv
// ----------------------------------------------------------------------------
// string_key_dual_hash_tb
// Drives byte strings into the key block and gives the verdict. A short
// directed set covers one-byte strings, the eight-byte short limit and a
// register change part-way through a long string; random strings of mixed
// length follow over several signed_bytes settings, with random idling on
// both channels, a calm stretch and one long receiver hold-off. Checking
// is done by the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module string_key_dual_hash_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbh_pkg::*;

  localparam int RandBytes  = 1150;    // random part, split over four phases
  localparam int IdlePct    = 22;      // idle chance per cycle, both sides
  localparam int HoldCycles = 120;     // long receiver hold-off
  localparam int IdleTail   = 8;       // drain margin after the last due key
  localparam int CycleLimit = 200_000;

  // DUT inputs, known from time zero
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_beat_t  in_data_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic      cfg_wdata_i = 1'b0;

  logic      in_stall_o;
  logic      out_valid_o;
  out_beat_t out_data_o;

  // from the checker
  int pending;
  int fails;
  int keys_seen;

  // idling control shared by sender and receiver
  logic calm      = 1'b0;  // high: neither side idles
  int   hold_req  = 0;     // bumped by the stimulus to ask for a hold-off
  int   hold_seen = 0;
  int   hold_left = 0;

  // run statistics for the summary
  int cycles       = 0;
  int bytes_sent   = 0;
  int strings_sent = 0;
  int short_count  = 0;
  int long_count   = 0;
  int run_len      = 0;
  int cfg_writes   = 0;

  always #1 clk_i = ~clk_i;

  string_key_dual_hash u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  string_key_dual_hash_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pending_o   (pending),
    .fails_o     (fails),
    .keys_seen_o (keys_seen)
  );

  // Watchdog: ends the run with a failure once CycleLimit is reached.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d keys still due", cycles, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off on request. The hold is
  // counted here so the sender keeps offering beats meanwhile and the
  // block backs up into its input.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen   <= hold_req;
      hold_left   <= HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
    end
  end

  // Offer one byte beat, with random idle cycles ahead of it, and hold it
  // until accepted. Valid is left high so back-to-back beats need no gap.
  task automatic send_beat(input logic [7:0] octet, input logic last);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= in_beat_t'{data_byte: octet, is_last: last};
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    run_len++;
    if (last) begin
      strings_sent++;
      if (run_len <= ShortLimitDef) begin
        short_count++;
      end else begin
        long_count++;
      end
      run_len = 0;
    end
  endtask

  // Send n bytes taken from the low end of a vector, byte 0 first.
  task automatic send_packed(input logic [71:0] octets, input int n, input logic close);
    int i;
    for (i = 0; i < n; i++) begin
      send_beat(octets[8*i +: 8], close && (i == n - 1));
    end
  endtask

  // Random string: mostly around the short limit, some very short, some long.
  // Bytes lean towards the sign boundary and the all-zero / all-one values.
  task automatic send_random_string();
    int          len;
    int          pick;
    int          i;
    logic [7:0]  octet;
    pick = $urandom_range(99);
    if (pick < 15) begin
      len = $urandom_range(3, 1);
    end else if (pick < 60) begin
      len = $urandom_range(10, 6);
    end else if (pick < 88) begin
      len = $urandom_range(16, 11);
    end else begin
      len = $urandom_range(40, 17);
    end
    for (i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0:       octet = 8'h00;
        1:       octet = 8'hFF;
        2:       octet = 8'h80;
        3:       octet = 8'h7F;
        default: octet = 8'($urandom_range(255));
      endcase
      send_beat(octet, i == len - 1);
    end
  endtask

  // Drop valid, wait until every due key has been taken, then let the
  // pipeline drain any bytes that carry no result.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (IdleTail) @(posedge clk_i);
  endtask

  task automatic write_signed(input logic value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    int   phase;
    int   start;
    logic sign;
    bit   pressed;
    pressed = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, with signed_bytes at its reset value
    send_packed(72'h00, 1, 1'b1);                        // single zero byte
    send_packed(72'hFF, 1, 1'b1);                        // single top byte
    // exactly at the short limit: raw bytes, sign ignored
    send_packed(72'h55_81_FE_00_01_FF_7F_80, 8, 1'b1);
    // nine-byte string with the register flipped part-way: the first
    // four bytes are summed signed, the last five unsigned
    send_packed(72'h00_7F_80_FF, 4, 1'b0);
    write_signed(1'b0);
    send_packed(72'hC3_01_80_FE_FF, 5, 1'b1);

    // Random phases over both register values
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       sign = 1'b1;
        1:       sign = 1'b0;
        2:       sign = 1'b1;
        default: sign = 1'($urandom_range(1));
      endcase
      write_signed(sign);
      start = bytes_sent;
      if (phase == 2) begin
        calm <= 1'b1;                                    // no idling at all
      end
      while (bytes_sent - start < RandBytes / 4) begin
        send_random_string();
        if (phase == 1 && !pressed && bytes_sent - start >= 40) begin
          hold_req <= hold_req + 1;
          pressed = 1'b1;
        end
        if (phase == 2 && calm && bytes_sent - start >= 150) begin
          calm <= 1'b0;
        end
      end
    end

    wait_idle();

    $display("Summary: %0d bytes in %0d strings (%0d short, %0d long), %0d keys compared",
             bytes_sent, strings_sent, short_count, long_count, keys_seen);
    $display("Summary: signed_bytes written %0d times, one %0d-cycle receiver hold-off",
             cfg_writes, HoldCycles);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", fails);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/sbh_pkg.sv
rtl/sbh_hash_core.sv
rtl/sbh_out_reg.sv
rtl/string_key_dual_hash.sv
dv/string_key_dual_hash_checker.sv
dv/string_key_dual_hash_tb.sv
